// ----- rtl/core/mmpp_pkg.sv -----
package mmpp_pkg;

  localparam int unsigned CNT_W = 31;
  localparam int unsigned LVL_W = 4;
  localparam int unsigned SMP_W = 16;

  // token walking up the chain of level cells
  typedef struct packed {
    logic                     vld;
    logic                     flush;  // 0: merge walk, 1: end-of-stream flush walk
    logic                     cv;     // flush: a carried pair is present
    logic signed [SMP_W-1:0]  mn;
    logic signed [SMP_W-1:0]  mx;
    logic [CNT_W:0]           cnt;    // walk: index at this level, flush: pair count
  } tok_t;

  // what a cell reports for the cycle it holds the token
  typedef struct packed {
    logic                     vld;    // a result item is produced
    logic                     done;   // the walk ends at this cell
    logic [LVL_W-1:0]         level;
    logic [CNT_W-1:0]         idx;
    logic signed [SMP_W-1:0]  mn;
    logic signed [SMP_W-1:0]  mx;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_FLUSH
  } st_t;

endpackage

// ----- rtl/core/mmpp_cell.sv -----
module mmpp_cell #(
  parameter int unsigned IDX  = 0,
  parameter bit          LAST = 1'b0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            clr,
  input  mmpp_pkg::tok_t  tok_i,
  output mmpp_pkg::tok_t  tok_o,
  output mmpp_pkg::res_t  res_o
);

  localparam logic [mmpp_pkg::LVL_W-1:0] LVL = mmpp_pkg::LVL_W'(IDX + 1);

  logic                              pv_r, pv_nxt;
  logic signed [mmpp_pkg::SMP_W-1:0] pmin_r, pmin_nxt;
  logic signed [mmpp_pkg::SMP_W-1:0] pmax_r, pmax_nxt;
  mmpp_pkg::tok_t                    tok_r, tok_nxt;

  logic signed [mmpp_pkg::SMP_W-1:0] mrg_mn, mrg_mx;
  logic signed [mmpp_pkg::SMP_W-1:0] fl_mn, fl_mx;
  logic                              fl_cv;
  logic [mmpp_pkg::CNT_W:0]          cnext;

  always_comb begin
    mrg_mn = (pmin_r < tok_i.mn) ? pmin_r : tok_i.mn;
    mrg_mx = (pmax_r > tok_i.mx) ? pmax_r : tok_i.mx;
    fl_cv  = tok_i.cv | pv_r;
    if (pv_r && tok_i.cv) begin
      fl_mn = mrg_mn;
      fl_mx = mrg_mx;
    end else if (pv_r) begin
      fl_mn = pmin_r;
      fl_mx = pmax_r;
    end else begin
      fl_mn = tok_i.mn;
      fl_mx = tok_i.mx;
    end
    cnext = (mmpp_pkg::CNT_W+1)'(({1'b0, tok_i.cnt} + (mmpp_pkg::CNT_W+2)'(1)) >> 1);

    pv_nxt    = pv_r;
    pmin_nxt  = pmin_r;
    pmax_nxt  = pmax_r;
    tok_nxt   = tok_r;
    tok_nxt.vld = 1'b0;
    res_o     = '0;

    if (tok_i.vld) begin
      // report only from the cell holding the token; the top level ORs all cells
      res_o.level = LVL;
      if (!tok_i.flush) begin
        if (pv_r) begin
          // partner waiting: merge, emit one level up, carry on unless this is the last cell
          pv_nxt    = 1'b0;
          res_o.vld = 1'b1;
          res_o.idx = tok_i.cnt[mmpp_pkg::CNT_W:1];
          res_o.mn  = mrg_mn;
          res_o.mx  = mrg_mx;
          if (LAST) begin
            res_o.done = 1'b1;
          end else begin
            tok_nxt.vld   = 1'b1;
            tok_nxt.flush = 1'b0;
            tok_nxt.cv    = 1'b0;
            tok_nxt.mn    = mrg_mn;
            tok_nxt.mx    = mrg_mx;
            tok_nxt.cnt   = {1'b0, tok_i.cnt[mmpp_pkg::CNT_W:1]};
          end
        end else begin
          // hold the pair until its partner arrives
          pv_nxt     = 1'b1;
          pmin_nxt   = tok_i.mn;
          pmax_nxt   = tok_i.mx;
          res_o.done = 1'b1;
        end
      end else begin
        if (tok_i.cnt <= (mmpp_pkg::CNT_W+1)'(1)) begin
          res_o.done = 1'b1;
        end else begin
          pv_nxt    = 1'b0;
          res_o.vld = fl_cv;
          res_o.idx = mmpp_pkg::CNT_W'(cnext - (mmpp_pkg::CNT_W+1)'(1));
          res_o.mn  = fl_mn;
          res_o.mx  = fl_mx;
          if (LAST) begin
            res_o.done = 1'b1;
          end else begin
            tok_nxt.vld   = 1'b1;
            tok_nxt.flush = 1'b1;
            tok_nxt.cv    = fl_cv;
            tok_nxt.mn    = fl_mn;
            tok_nxt.mx    = fl_mx;
            tok_nxt.cnt   = cnext;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r      <= 1'b0;
      tok_r.vld <= 1'b0;
    end else if (en) begin
      pv_r  <= clr ? 1'b0 : pv_nxt;
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pmin_r <= pmin_nxt;
      pmax_r <= pmax_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

// ----- rtl/core/min_max_peak_pyramid_core.sv -----
// Min/max peak pyramid over a stream of base-level (min, max) pairs.
// Input channel: in_valid/in_ready with in_pair_min, in_pair_max and
// in_end_of_stream; one item is one base pair. Result channel:
// out_valid/out_ready with out_level, out_pair_index, out_min, out_max and
// out_last, which marks the final result of each input item.
// Each item produces its level-0 result, then a token walks up a chain of
// LEVELS-1 level cells, one cell per cycle unless the output stalls,
// emitting a merged pair at each level that completes. On end_of_stream a
// second walk flushes the odd leftover pairs and clears every level. A new
// item is accepted only in idle, after the walk of the previous item (and
// its flush walk on end_of_stream) has ended. The level-0 result waits in the
// result stage before it moves into the output register.
// Reset (rst_n, synchronous) empties all levels and the output registers
// and starts a new stream at pair index 0. When out_ready is low the walk
// holds in place once its result stage and output register are full;
// nothing is dropped.
module min_max_peak_pyramid_core #(
  parameter int unsigned LEVELS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [mmpp_pkg::SMP_W-1:0]   in_pair_min,
  input  logic signed [mmpp_pkg::SMP_W-1:0]   in_pair_max,
  input  logic                                in_end_of_stream,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mmpp_pkg::LVL_W-1:0]          out_level,
  output logic [mmpp_pkg::CNT_W-1:0]          out_pair_index,
  output logic signed [mmpp_pkg::SMP_W-1:0]   out_min,
  output logic signed [mmpp_pkg::SMP_W-1:0]   out_max,
  output logic                                out_last
);

  localparam int unsigned NCELL = LEVELS - 1;

  mmpp_pkg::st_t  state_r, state_nxt;
  mmpp_pkg::tok_t tok [NCELL];
  mmpp_pkg::res_t res [NCELL];
  mmpp_pkg::res_t res_all;

  mmpp_pkg::tok_t inj_r, inj_nxt;
  logic [mmpp_pkg::CNT_W-1:0] base_r, base_nxt;
  logic eos_r, eos_nxt;
  logic clr;

  logic                              hold_v_r, hold_v_nxt;
  logic [mmpp_pkg::LVL_W-1:0]        hold_lvl_r, hold_lvl_nxt;
  logic [mmpp_pkg::CNT_W-1:0]        hold_idx_r, hold_idx_nxt;
  logic signed [mmpp_pkg::SMP_W-1:0] hold_mn_r, hold_mn_nxt;
  logic signed [mmpp_pkg::SMP_W-1:0] hold_mx_r, hold_mx_nxt;

  logic                              out_valid_r, out_valid_nxt;
  logic [mmpp_pkg::LVL_W-1:0]        out_lvl_r;
  logic [mmpp_pkg::CNT_W-1:0]        out_idx_r;
  logic signed [mmpp_pkg::SMP_W-1:0] out_mn_r, out_mx_r;
  logic                              out_last_r;

  logic out_free, en, acc, fin, emit, done, load, load_last;

  assign tok[0] = inj_r;

  genvar gi;
  generate
    for (gi = 0; gi < NCELL; gi++) begin : g_cell
      if (gi == NCELL - 1) begin : g_top
        mmpp_cell #(.IDX(gi), .LAST(1'b1)) u_cell (
          .clk   (clk),
          .rst_n (rst_n),
          .en    (en),
          .clr   (clr),
          .tok_i (tok[gi]),
          .tok_o (),
          .res_o (res[gi])
        );
      end else begin : g_mid
        mmpp_cell #(.IDX(gi), .LAST(1'b0)) u_cell (
          .clk   (clk),
          .rst_n (rst_n),
          .en    (en),
          .clr   (clr),
          .tok_i (tok[gi]),
          .tok_o (tok[gi+1]),
          .res_o (res[gi])
        );
      end
    end
  endgenerate

  // only one cell holds the token, so an OR picks its report
  always_comb begin
    res_all = '0;
    for (int i = 0; i < NCELL; i++) begin
      res_all = mmpp_pkg::res_t'(res_all | res[i]);
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign en       = !hold_v_r || out_free;
  assign in_ready = (state_r == mmpp_pkg::ST_IDLE) && en;
  assign acc      = in_valid && in_ready;
  assign fin      = (state_r == mmpp_pkg::ST_IDLE) && hold_v_r && out_free;
  assign emit     = en && res_all.vld;
  assign done     = en && res_all.done;

  always_comb begin
    state_nxt = state_r;
    inj_nxt   = inj_r;
    base_nxt  = base_r;
    eos_nxt   = eos_r;
    clr       = 1'b0;
    if (en) begin
      inj_nxt.vld = 1'b0;
    end
    case (state_r)
      mmpp_pkg::ST_IDLE: begin
        if (acc) begin
          inj_nxt.vld   = 1'b1;
          inj_nxt.flush = 1'b0;
          inj_nxt.cv    = 1'b0;
          inj_nxt.mn    = in_pair_min;
          inj_nxt.mx    = in_pair_max;
          inj_nxt.cnt   = {1'b0, base_r};
          eos_nxt       = in_end_of_stream;
          state_nxt     = mmpp_pkg::ST_STEP;
        end
      end
      mmpp_pkg::ST_STEP: begin
        if (done) begin
          if (eos_r) begin
            // start the flush walk with the pair count of this stream
            inj_nxt.vld   = 1'b1;
            inj_nxt.flush = 1'b1;
            inj_nxt.cv    = 1'b0;
            inj_nxt.mn    = '0;
            inj_nxt.mx    = '0;
            inj_nxt.cnt   = {1'b0, base_r} + (mmpp_pkg::CNT_W+1)'(1);
            state_nxt     = mmpp_pkg::ST_FLUSH;
          end else begin
            base_nxt  = base_r + mmpp_pkg::CNT_W'(1);
            state_nxt = mmpp_pkg::ST_IDLE;
          end
        end
      end
      mmpp_pkg::ST_FLUSH: begin
        if (done) begin
          clr       = 1'b1;
          base_nxt  = '0;
          state_nxt = mmpp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mmpp_pkg::ST_IDLE;
      end
    endcase
  end

  // hold the newest result until the next one shows whether it was the last
  always_comb begin
    hold_v_nxt   = hold_v_r;
    hold_lvl_nxt = hold_lvl_r;
    hold_idx_nxt = hold_idx_r;
    hold_mn_nxt  = hold_mn_r;
    hold_mx_nxt  = hold_mx_r;
    load         = 1'b0;
    load_last    = 1'b0;
    if (fin) begin
      load       = 1'b1;
      load_last  = 1'b1;
      hold_v_nxt = 1'b0;
    end else if (emit && hold_v_r) begin
      load = 1'b1;
    end
    if (acc) begin
      hold_v_nxt   = 1'b1;
      hold_lvl_nxt = '0;
      hold_idx_nxt = base_r;
      hold_mn_nxt  = in_pair_min;
      hold_mx_nxt  = in_pair_max;
    end else if (emit) begin
      hold_v_nxt   = 1'b1;
      hold_lvl_nxt = res_all.level;
      hold_idx_nxt = res_all.idx;
      hold_mn_nxt  = res_all.mn;
      hold_mx_nxt  = res_all.mx;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mmpp_pkg::ST_IDLE;
      inj_r.vld   <= 1'b0;
      base_r      <= '0;
      eos_r       <= 1'b0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      inj_r       <= inj_nxt;
      base_r      <= base_nxt;
      eos_r       <= eos_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_lvl_r <= hold_lvl_nxt;
    hold_idx_r <= hold_idx_nxt;
    hold_mn_r  <= hold_mn_nxt;
    hold_mx_r  <= hold_mx_nxt;
    if (load) begin
      out_lvl_r  <= hold_lvl_r;
      out_idx_r  <= hold_idx_r;
      out_mn_r   <= hold_mn_r;
      out_mx_r   <= hold_mx_r;
      out_last_r <= load_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_level      = out_lvl_r;
  assign out_pair_index = out_idx_r;
  assign out_min        = out_mn_r;
  assign out_max        = out_mx_r;
  assign out_last       = out_last_r;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CNT_W = mmpp_pkg::CNT_W;
  localparam int unsigned LVL_W = mmpp_pkg::LVL_W;
  localparam int unsigned SMP_W = mmpp_pkg::SMP_W;

  localparam int unsigned LEVELS       = 16;
  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned TAIL_CYCLES  = 64;
  localparam int unsigned HOLD_OFF_LEN = 300;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic [LVL_W-1:0]        level;
    logic [CNT_W-1:0]        idx;
    logic signed [SMP_W-1:0] mn;
    logic signed [SMP_W-1:0] mx;
    logic                    last;
  } peak_pair_t;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [SMP_W-1:0] in_pair_min;
  logic signed [SMP_W-1:0] in_pair_max;
  logic                    in_end_of_stream;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [LVL_W-1:0]        out_level;
  logic [CNT_W-1:0]        out_pair_index;
  logic signed [SMP_W-1:0] out_min;
  logic signed [SMP_W-1:0] out_max;
  logic                    out_last;

  // pyramid state as the block should hold it
  logic [CNT_W-1:0]        base_cnt;
  bit                      pend_vld [LEVELS-1];
  logic signed [SMP_W-1:0] pend_mn  [LEVELS-1];
  logic signed [SMP_W-1:0] pend_mx  [LEVELS-1];
  peak_pair_t              want_pairs [$];
  peak_pair_t              head_pair;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned fail_cnt       = 0;
  int unsigned items_sent     = 0;
  int unsigned streams_sent   = 0;
  int unsigned pairs_checked  = 0;
  int unsigned hold_off_left  = 0;
  logic        hold_off_tgl   = 1'b0;
  logic        hold_off_seen  = 1'b0;

  min_max_peak_pyramid_core #(
    .LEVELS(LEVELS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pair_min     (in_pair_min),
    .in_pair_max     (in_pair_max),
    .in_end_of_stream(in_end_of_stream),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_level       (out_level),
    .out_pair_index  (out_pair_index),
    .out_min         (out_min),
    .out_max         (out_max),
    .out_last        (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d pairs still expected",
               cycle_cnt, want_pairs.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // long receiver hold-off, counted here only
  always @(posedge clk) begin
    if (hold_off_tgl != hold_off_seen) begin
      hold_off_seen <= hold_off_tgl;
      hold_off_left <= HOLD_OFF_LEN;
    end else if (hold_off_left != 0) begin
      hold_off_left <= hold_off_left - 1;
    end
  end

  function automatic void push_pair(input int unsigned lvl, input logic [CNT_W:0] idx,
                                    input logic signed [SMP_W-1:0] mn,
                                    input logic signed [SMP_W-1:0] mx);
    peak_pair_t p;
    p.level = lvl[LVL_W-1:0];
    p.idx   = idx[CNT_W-1:0];
    p.mn    = mn;
    p.mx    = mx;
    p.last  = 1'b0;
    want_pairs.push_back(p);
  endfunction

  function automatic void clear_pyramid();
    int lv;
    base_cnt = '0;
    for (lv = 0; lv < LEVELS - 1; lv++) begin
      pend_vld[lv] = 1'b0;
      pend_mn[lv]  = '0;
      pend_mx[lv]  = '0;
    end
  endfunction

  function automatic void pyramid_step(input logic signed [SMP_W-1:0] pmin,
                                       input logic signed [SMP_W-1:0] pmax,
                                       input logic eos);
    logic signed [SMP_W-1:0] lo, hi, cmin, cmax;
    logic [CNT_W-1:0]        n;
    logic [CNT_W:0]          c;
    bit                      cv, walking;
    int                      lv;
    lo = pmin;
    hi = pmax;
    n = base_cnt;
    cmin = '0;
    cmax = '0;
    cv = 1'b0;
    walking = 1'b1;
    push_pair(0, {1'b0, n}, lo, hi);
    // merge upward until a level has no partner waiting
    for (lv = 0; lv < LEVELS - 1 && walking; lv++) begin
      if (pend_vld[lv]) begin
        if (pend_mn[lv] < lo) lo = pend_mn[lv];
        if (pend_mx[lv] > hi) hi = pend_mx[lv];
        pend_vld[lv] = 1'b0;
        push_pair(lv + 1, {1'b0, n} >> (lv + 1), lo, hi);
      end else begin
        pend_vld[lv] = 1'b1;
        pend_mn[lv]  = lo;
        pend_mx[lv]  = hi;
        walking = 1'b0;
      end
    end
    if (eos) begin
      c = {1'b0, n} + 1;
      // flush leftovers only on levels that exist for this pair count
      for (lv = 0; lv < LEVELS - 1 && c > 1; lv++) begin
        if (pend_vld[lv]) begin
          if (cv) begin
            if (pend_mn[lv] < cmin) cmin = pend_mn[lv];
            if (pend_mx[lv] > cmax) cmax = pend_mx[lv];
          end else begin
            cmin = pend_mn[lv];
            cmax = pend_mx[lv];
            cv = 1'b1;
          end
        end
        c = (c + 1) / 2;
        if (cv) push_pair(lv + 1, c - 1, cmin, cmax);
      end
      clear_pyramid();
    end else begin
      base_cnt = n + CNT_W'(1);
    end
    want_pairs[want_pairs.size() - 1].last = 1'b1;
  endfunction

  task automatic flag_error(input string what, input bit have_want, input peak_pair_t want);
    if (fail_cnt < MAX_REPORTS) begin
      if (have_want)
        $display("ERROR %s: want L%0d #%0d [%0d,%0d] last=%0b, got L%0d #%0d [%0d,%0d] last=%0b",
                 what, want.level, want.idx, want.mn, want.mx, want.last,
                 out_level, out_pair_index, out_min, out_max, out_last);
      else
        $display("ERROR %s: got L%0d #%0d [%0d,%0d] last=%0b",
                 what, out_level, out_pair_index, out_min, out_max, out_last);
    end
    fail_cnt++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (hold_off_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        pairs_checked++;
        if (want_pairs.size() == 0) begin
          flag_error("unexpected result", 1'b0, head_pair);
        end else begin
          head_pair = want_pairs.pop_front();
          if (out_level !== head_pair.level || out_pair_index !== head_pair.idx ||
              out_min !== head_pair.mn || out_max !== head_pair.mx ||
              out_last !== head_pair.last)
            flag_error("result mismatch", 1'b1, head_pair);
        end
      end
    end
  end

  function automatic logic signed [SMP_W-1:0] rand_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      default: return r[SMP_W-1:0];
    endcase
  endfunction

  task automatic send_pair(input logic signed [SMP_W-1:0] pmin,
                           input logic signed [SMP_W-1:0] pmax, input logic eos);
    int unsigned gap;
    gap = 0;
    while (gap < 20 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_pair_min      <= pmin;
    in_pair_max      <= pmax;
    in_end_of_stream <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pyramid_step(pmin, pmax, eos);
    items_sent++;
    if (eos) streams_sent++;
  endtask

  task automatic send_stream(input int unsigned len);
    int unsigned k;
    for (k = 1; k <= len; k++) send_pair(rand_sample(), rand_sample(), k == len);
  endtask

  // drop valid and hold until every expected pair has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (want_pairs.size() != 0) @(posedge clk);
  endtask

  task automatic test_single_pair_streams();
    send_pair(16'sh8000, 16'sh7fff, 1'b1);
    send_pair(16'sh7fff, 16'sh8000, 1'b1);
    send_pair(16'sh0000, -16'sd1, 1'b1);
    wait_drained();
  endtask

  task automatic test_extreme_values();
    send_pair(16'sh8000, 16'sh8000, 1'b0);
    send_pair(16'sh7fff, 16'sh7fff, 1'b0);
    send_pair(-16'sd1, 16'sh0000, 1'b0);
    send_pair(16'sd1, -16'sd2, 1'b1);
    wait_drained();
  endtask

  task automatic test_odd_leftovers();
    send_stream(5);
    send_stream(3);
    send_stream(2);
    wait_drained();
  endtask

  task automatic test_power_of_two();
    // full binary tree: flush has nothing left over
    send_stream(8);
    wait_drained();
  endtask

  task automatic test_random_streams(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned n_items);
    int unsigned sent, len;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
      send_stream(len);
      sent += len;
    end
    wait_drained();
  endtask

  task automatic test_output_hold_off();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_tgl <= ~hold_off_tgl;
    send_stream(17);
    send_stream(13);
    wait_drained();
  endtask

  task automatic test_deep_stream();
    // one past a power of two: the lone last pair is carried up to the highest level this pair count reaches
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_stream(33);
    wait_drained();
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_pair_min      = '0;
    in_pair_max      = '0;
    in_end_of_stream = 1'b0;
    clear_pyramid();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_pair_streams();
    test_extreme_values();
    test_odd_leftovers();
    test_power_of_two();
    test_random_streams(0, 0, 25);
    test_random_streams(50, 0, 25);
    test_random_streams(0, 50, 25);
    test_random_streams(29, 29, 25);
    test_output_hold_off();
    test_deep_stream();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d items in %0d streams; %0d results checked.",
             items_sent, streams_sent, pairs_checked);
    $display("Phases: directed edges, idle/stall mixes, a long output hold-off, a deep stream.");
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d failures", fail_cnt);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- min_max_peak_pyramid_core.f -----
rtl/core/mmpp_pkg.sv
rtl/core/mmpp_cell.sv
rtl/core/min_max_peak_pyramid_core.sv
dv/tb_top.sv
